/* src/salu_pkg.sv */
// Package for the stack ALU: action codes, port widths, default sizes and
// the command and status structs between controller and datapath.
// No dependencies.
package salu_pkg;

   localparam int DEFAULT_STACK_DEPTH = 8;
   localparam int DEFAULT_WORD_BITS   = 8;

   localparam int ACTION_BITS = 3;
   localparam int PORT_WORD_BITS = 8;
   localparam int FILL_BITS   = 4;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_PUSH = 3'd0,
      ACT_POP  = 3'd1,
      ACT_ADD  = 3'd2,
      ACT_SUB  = 3'd3,
      ACT_MUL  = 3'd4,
      ACT_DIV  = 3'd5
   } action_type;

   // Commands from the controller, one step of the sequence per cycle.
   typedef struct packed {
      logic latch;       // capture the request, clear the per-item flags
      logic pop;         // read the top word, drop the level if not empty
      logic pop_second;  // the pop fills operand B instead of the first slot
      logic cap_first;   // take the read word as operand A or popped word
      logic cap_second;  // take the read word as operand B
      logic calc;        // form the arithmetic result
      logic push;        // write a word on top if there is room
      logic respond;     // load the response registers
   } salu_cmd_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
   } salu_stat_type;

endpackage

/* src/salu_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module salu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/salu_ctrl.sv */
// Sequencer of the stack ALU: walks each action through its pops, its
// arithmetic step, its push and its response. Depends on salu_pkg.
module salu_ctrl
   import salu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  salu_stat_type stat,
   output salu_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_POP_A,
      S_CAP_A,
      S_POP_B,
      S_CAP_B,
      S_CALC,
      S_PUSH,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      strobe_in;
   logic      strobe_ff;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.action)
               ACT_PUSH: state_in = S_PUSH;
               ACT_POP, ACT_ADD, ACT_SUB, ACT_MUL: state_in = S_POP_A;
               default: state_in = S_RESP;
            endcase
         end
         S_POP_A: begin
            cmd.pop  = 1'b1;
            state_in = S_CAP_A;
         end
         S_CAP_A: begin
            cmd.cap_first = 1'b1;
            state_in = (stat.action == ACT_POP) ? S_RESP : S_POP_B;
         end
         S_POP_B: begin
            cmd.pop        = 1'b1;
            cmd.pop_second = 1'b1;
            state_in       = S_CAP_B;
         end
         S_CAP_B: begin
            cmd.cap_second = 1'b1;
            state_in       = S_CALC;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            strobe_in   = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

/* src/salu_dp.sv */
// Datapath of the stack ALU: stack memory, fill level, operand and result
// registers, and the response registers. Depends on salu_pkg and salu_ram.
module salu_dp
   import salu_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
   parameter int WORD_BITS   = DEFAULT_WORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  salu_cmd_type                     cmd,
   output salu_stat_type                    stat,
   input  logic [ACTION_BITS-1:0]           req_action,
   input  logic signed [PORT_WORD_BITS-1:0] req_push_value,
   output logic signed [PORT_WORD_BITS-1:0] rsp_result_value,
   output logic                             rsp_push_ok,
   output logic                             rsp_first_pop_ok,
   output logic                             rsp_second_pop_ok,
   output logic [FILL_BITS-1:0]             rsp_fill_level
);

   localparam int LEVEL_BITS = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_BITS  = $clog2(STACK_DEPTH);

   logic [ACTION_BITS-1:0] action_ff;
   logic [WORD_BITS-1:0]   push_word_ff;
   logic [WORD_BITS-1:0]   value_ff;
   logic [WORD_BITS-1:0]   opa_ff;
   logic [WORD_BITS-1:0]   opb_ff;
   logic [LEVEL_BITS-1:0]  level_ff;
   logic                   first_ok_ff;
   logic                   second_ok_ff;
   logic                   pushed_ff;

   logic                        empty;
   logic                        full;
   logic [WORD_BITS-1:0]        rd_data;
   logic [WORD_BITS-1:0]        wr_data;
   logic                        wr_en;
   logic [2*WORD_BITS-1:0]      product;
   logic [WORD_BITS-1:0]        calc_word;

   logic signed [PORT_WORD_BITS-1:0] rsp_result_value_ff;
   logic                             rsp_push_ok_ff;
   logic                             rsp_first_pop_ok_ff;
   logic                             rsp_second_pop_ok_ff;
   logic [FILL_BITS-1:0]             rsp_fill_level_ff;

   assign empty = (level_ff == '0);
   assign full  = (level_ff == LEVEL_BITS'(STACK_DEPTH));
   assign stat.action = action_ff;

   // A word pushed by an arithmetic action is its result.
   assign wr_en   = cmd.push && !full;
   assign wr_data = (action_ff == ACT_PUSH) ? push_word_ff : value_ff;

   salu_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (level_ff[ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.pop),
      .rd_addr (ADDR_BITS'(level_ff - LEVEL_BITS'(1))),
      .rd_data (rd_data)
   );

   assign product = (2*WORD_BITS)'(opa_ff) * (2*WORD_BITS)'(opb_ff);

   always_comb begin
      case (action_ff)
         ACT_ADD: calc_word = opa_ff + opb_ff;
         ACT_SUB: calc_word = opa_ff - opb_ff;
         default: calc_word = product[WORD_BITS-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         opa_ff       <= '0;
         opb_ff       <= '0;
         first_ok_ff  <= 1'b0;
         second_ok_ff <= 1'b0;
         pushed_ff    <= 1'b0;
      end else begin
         if (cmd.latch) begin
            first_ok_ff  <= 1'b0;
            second_ok_ff <= 1'b0;
            pushed_ff    <= 1'b0;
         end
         if (cmd.pop && !empty) begin
            level_ff <= level_ff - LEVEL_BITS'(1);
            if (cmd.pop_second) begin
               second_ok_ff <= 1'b1;
            end else begin
               first_ok_ff <= 1'b1;
            end
         end
         // A failed pop leaves the operand register as it was.
         if (cmd.cap_first && first_ok_ff && action_ff != ACT_POP) begin
            opa_ff <= rd_data;
         end
         if (cmd.cap_second && second_ok_ff) begin
            opb_ff <= rd_data;
         end
         if (wr_en) begin
            level_ff  <= level_ff + LEVEL_BITS'(1);
            pushed_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff    <= req_action;
         push_word_ff <= WORD_BITS'($unsigned(req_push_value));
         value_ff     <= '0;
      end
      if (cmd.cap_first && first_ok_ff && action_ff == ACT_POP) begin
         value_ff <= rd_data;
      end
      if (cmd.calc) begin
         value_ff <= calc_word;
      end
      if (cmd.respond) begin
         rsp_result_value_ff  <= PORT_WORD_BITS'(value_ff);
         rsp_push_ok_ff       <= pushed_ff;
         rsp_first_pop_ok_ff  <= first_ok_ff;
         rsp_second_pop_ok_ff <= second_ok_ff;
         rsp_fill_level_ff    <= FILL_BITS'(level_ff);
      end
   end

   assign rsp_result_value  = rsp_result_value_ff;
   assign rsp_push_ok       = rsp_push_ok_ff;
   assign rsp_first_pop_ok  = rsp_first_pop_ok_ff;
   assign rsp_second_pop_ok = rsp_second_pop_ok_ff;
   assign rsp_fill_level    = rsp_fill_level_ff;

endmodule

/* src/stack_alu.sv */
// Top level of the stack ALU: a bounded stack of words with add, subtract
// and multiply. Depends on salu_pkg, salu_ctrl, salu_dp and salu_ram.
//
// Usage. A request (req_action, req_push_value) is taken at a rising edge
// where start is high and busy is low; busy then stays high until the item
// is finished. Each request yields exactly one response, shown on the rsp_
// ports for one cycle while rsp_strobe is high; that transfer cannot be held
// off by the receiver, so it must sample the response in that cycle.
// The sequencer steps through the single-read stack memory one access per
// cycle: after a decode state, a push goes through a push state; a pop
// through a pop and a capture state; add, subtract and multiply through
// two pops with their captures, a calculate and a push state; divide and
// unused codes go straight on; every action ends in the response state.
// busy drops in the strobe cycle, so a new request can be accepted there,
// but not while the previous item is still being worked.
// Each pop reads the stack memory through its registered read port, and the
// arithmetic result is registered before it is pushed.
// Reset (synchronous, active high) empties the stack and clears both
// operand registers; no clearing pass over the memory is needed because a
// word read from a slot is only used after that slot has been written.
module stack_alu
   import salu_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
   parameter int WORD_BITS   = DEFAULT_WORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ACTION_BITS-1:0]           req_action,
   input  logic signed [PORT_WORD_BITS-1:0] req_push_value,
   output logic                             rsp_strobe,
   output logic signed [PORT_WORD_BITS-1:0] rsp_result_value,
   output logic                             rsp_push_ok,
   output logic                             rsp_first_pop_ok,
   output logic                             rsp_second_pop_ok,
   output logic [FILL_BITS-1:0]             rsp_fill_level
);

   salu_cmd_type  cmd;
   salu_stat_type stat;

   // The controller owns sequencing and the response strobe.
   salu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // The datapath holds the stack, the operands and the response fields.
   salu_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .WORD_BITS   (WORD_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_push_value    (req_push_value),
      .rsp_result_value  (rsp_result_value),
      .rsp_push_ok       (rsp_push_ok),
      .rsp_first_pop_ok  (rsp_first_pop_ok),
      .rsp_second_pop_ok (rsp_second_pop_ok),
      .rsp_fill_level    (rsp_fill_level)
   );

endmodule
